[hw/rtl/dwm_pkg.sv]
// Shared types and constants for the distinct window marker detector.
package dwm_pkg;

  localparam int unsigned MaxWindowDef = 16;
  localparam int unsigned LenW         = 5;
  localparam int unsigned PosW         = 16;
  localparam int unsigned CfgIdxW      = 1;

  localparam logic [LenW-1:0] ShortLenRst = LenW'(4);
  localparam logic [LenW-1:0] LongLenRst  = LenW'(14);
  localparam logic [PosW-1:0] PosMax      = '1;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgShortLen = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgLongLen  = 1'b1;

  // link handed from one history cell to the next
  typedef struct packed {
    logic [7:0] data;  // byte moving down the history
    logic       run;   // the receiving cell lies inside the new run
    logic       kill;  // a match was seen in an earlier cell
  } dwm_link_t;

endpackage

[hw/rtl/dwm_ifs.sv]
// Request channel interfaces: byte input and marker result output.
interface dwm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;

  modport source (output valid, output data_byte, output restart, input ready);
  modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface dwm_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] position;
  logic        short_distinct;
  logic        long_distinct;
  logic        short_first;
  logic        long_first;

  modport source (output valid, output position, output short_distinct,
                  output long_distinct, output short_first, output long_first,
                  input ready);
  modport sink   (input valid, input position, input short_distinct,
                  input long_distinct, input short_first, input long_first,
                  output ready);
endinterface

[hw/rtl/distinct_window_marker_detector_unit.sv]
// Results are registered: a result appears in the cycle after its request is accepted.
// Throughput: one byte per cycle while no waiting result is held back by out_ch.ready; the new run is found
// in a single pass along the cell chain, so the chain length MAX_WINDOW sets the critical path.
// Reset: run, position, found flags and output valid clear; lengths return to
// 4 and 14. Stored bytes are not cleared; they are masked by the run bits.
module distinct_window_marker_detector_unit
  import dwm_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = MaxWindowDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [LenW-1:0]    cfg_wdata_i,
  dwm_in_if.sink             in_ch,
  dwm_out_if.source          out_ch
);

  localparam int unsigned IdxW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned MaxW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned CmpW = (MaxW > LenW) ? MaxW : LenW;

  logic [LenW-1:0] short_len_q, long_len_q;
  logic [PosW-1:0] count_q, count_d;
  logic            found_s_q, found_l_q;
  logic            base_s, base_l;
  logic            out_valid_q;
  logic [PosW-1:0] pos_q;
  logic            sd_q, ld_q, sf_q, lf_q;

  logic            accept;
  logic            sd, ld;
  logic [IdxW-1:0] short_idx, long_idx;
  logic [MAX_WINDOW-1:0] new_run;

  dwm_link_t links [MAX_WINDOW+1];

  assign in_ch.ready = ~out_valid_q | out_ch.ready;
  assign accept      = in_ch.valid & in_ch.ready;

  // clamp a length to 2..MAX_WINDOW and turn it into a thermometer index
  function automatic logic [IdxW-1:0] len_idx(input logic [LenW-1:0] len);
    logic [CmpW-1:0] ext;
    logic [CmpW-1:0] eff;
    ext = CmpW'(len);
    if (ext < CmpW'(2)) begin
      eff = CmpW'(2);
    end else if (ext > CmpW'(MAX_WINDOW)) begin
      eff = CmpW'(MAX_WINDOW);
    end else begin
      eff = ext;
    end
    len_idx = IdxW'(eff - CmpW'(1));
  endfunction

  assign links[0].data = in_ch.data_byte;
  assign links[0].run  = 1'b1;
  assign links[0].kill = 1'b0;

  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    dwm_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (accept),
      .restart_i (in_ch.restart),
      .byte_i    (in_ch.data_byte),
      .link_i    (links[k]),
      .link_o    (links[k+1])
    );
    // new run as a thermometer: bit k set when the run covers k+1 bytes
    assign new_run[k] = links[k].run;
  end

  assign short_idx = len_idx(short_len_q);
  assign long_idx  = len_idx(long_len_q);
  assign sd        = new_run[short_idx];
  assign ld        = new_run[long_idx];

  assign base_s = found_s_q & ~in_ch.restart;
  assign base_l = found_l_q & ~in_ch.restart;

  always_comb begin
    if (in_ch.restart) begin
      count_d = PosW'(1);
    end else if (count_q == PosMax) begin
      count_d = PosMax;
    end else begin
      count_d = count_q + PosW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_len_q <= ShortLenRst;
      long_len_q  <= LongLenRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgShortLen: short_len_q <= cfg_wdata_i;
        CfgLongLen:  long_len_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      found_s_q   <= 1'b0;
      found_l_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q   <= count_d;
        found_s_q <= base_s | sd;
        found_l_q <= base_l | ld;
      end
      if (in_ch.ready) begin
        out_valid_q <= in_ch.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pos_q <= count_d;
      sd_q  <= sd;
      ld_q  <= ld;
      sf_q  <= sd & ~base_s;
      lf_q  <= ld & ~base_l;
    end
  end

  assign out_ch.valid          = out_valid_q;
  assign out_ch.position       = pos_q;
  assign out_ch.short_distinct = sd_q;
  assign out_ch.long_distinct  = ld_q;
  assign out_ch.short_first    = sf_q;
  assign out_ch.long_first     = lf_q;

endmodule

[hw/rtl/dwm_cell.sv]
// One history cell: stores a byte and its run membership, compares against the new byte.
module dwm_cell
  import dwm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      restart_i,
  input  logic [7:0] byte_i,
  input  dwm_link_t link_i,
  output dwm_link_t link_o
);

  logic [7:0] data_q;
  logic       run_q;
  logic       run_eff;
  logic       match;

  // restart empties the run, so no stored byte takes part
  assign run_eff     = run_q & ~restart_i;
  assign match       = run_eff && (data_q == byte_i);
  assign link_o.kill = link_i.kill | match;
  assign link_o.run  = run_eff & ~link_o.kill;
  assign link_o.data = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else if (en_i) begin
      run_q <= link_i.run;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= link_i.data;
    end
  end

endmodule

[tb/distinct_window_marker_detector_unit_tb.sv]
// Self-checking testbench for the distinct window marker detector: directed and random streams.
module distinct_window_marker_detector_unit_tb
  import dwm_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [PosW-1:0] position;
    logic            short_distinct;
    logic            long_distinct;
    logic            short_first;
    logic            long_first;
  } marker_t;

  // Predicts the marker flags per byte and holds them until the result comes back
  class marker_scoreboard;
    logic [7:0]      hist [MaxWindowDef];
    int unsigned     run;
    logic [PosW-1:0] count;
    bit              found_short;
    bit              found_long;
    logic [LenW-1:0] short_len;
    logic [LenW-1:0] long_len;
    marker_t         expected_q [$];
    int unsigned     fails;

    function new();
      short_len = ShortLenRst;
      long_len  = LongLenRst;
      fails     = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      int k;
      for (k = 0; k < MaxWindowDef; k++) hist[k] = 8'h00;
      run         = 0;
      count       = '0;
      found_short = 1'b0;
      found_long  = 1'b0;
    endfunction

    function int unsigned window_len(logic [LenW-1:0] len);
      if (len < 2) return 2;
      if (len > MaxWindowDef) return MaxWindowDef;
      return len;
    endfunction

    function void set_len(logic [CfgIdxW-1:0] idx, logic [LenW-1:0] val);
      if (idx == CfgShortLen) short_len = val;
      else if (idx == CfgLongLen) long_len = val;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_request(logic [7:0] b, logic restart);
      int unsigned nrun;
      int          k;
      bit          hit;
      marker_t     m;
      if (restart) clear_stream();
      // the nearest earlier copy inside the run cuts the run short
      nrun = run + 1;
      hit  = 1'b0;
      for (k = 0; k < run && k < MaxWindowDef && !hit; k++) begin
        if (hist[k] == b) begin
          nrun = k + 1;
          hit  = 1'b1;
        end
      end
      if (nrun > MaxWindowDef) nrun = MaxWindowDef;
      run = nrun;
      for (k = MaxWindowDef - 1; k > 0; k--) hist[k] = hist[k-1];
      hist[0] = b;
      if (count != PosMax) count++;
      m.position       = count;
      m.short_distinct = (run >= window_len(short_len));
      m.long_distinct  = (run >= window_len(long_len));
      m.short_first    = m.short_distinct && !found_short;
      m.long_first     = m.long_distinct && !found_long;
      if (m.short_distinct) found_short = 1'b1;
      if (m.long_distinct) found_long = 1'b1;
      expected_q.push_back(m);
    endfunction

    function void cmp_field(string name, int unsigned exp_v, int unsigned got_v);
      if (exp_v != got_v) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
        fails++;
      end
    endfunction

    function void check_result(marker_t got);
      marker_t exp_m;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: position %0d", got.position);
        fails++;
        return;
      end
      exp_m = expected_q.pop_front();
      cmp_field("position", exp_m.position, got.position);
      cmp_field("short_distinct", exp_m.short_distinct, got.short_distinct);
      cmp_field("long_distinct", exp_m.long_distinct, got.long_distinct);
      cmp_field("short_first", exp_m.short_first, got.short_first);
      cmp_field("long_first", exp_m.long_first, got.long_first);
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [LenW-1:0]    cfg_wdata_i;

  dwm_in_if  in_ch ();
  dwm_out_if out_ch ();

  distinct_window_marker_detector_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  marker_scoreboard sb = new();

  bit          tx_quiet = 1'b0;
  bit          rx_quiet = 1'b0;
  int unsigned hold_cycles = 0;

  // byte generator state
  int unsigned gen_mode = 0;
  int unsigned gen_left = 0;
  int unsigned seq_byte, seq_step, alpha_base, alpha_span;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #10ms;
    $display("FAIL distinct_window_marker_detector_unit");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  // mixes noise, small alphabets (many repeats) and long runs of distinct bytes
  function automatic logic [7:0] next_byte();
    if (gen_left == 0) begin
      gen_mode   = $urandom_range(0, 3);
      gen_left   = $urandom_range(4, 40);
      seq_byte   = $urandom_range(0, 255);
      seq_step   = 2 * $urandom_range(0, 127) + 1;
      alpha_base = $urandom_range(0, 255);
      alpha_span = $urandom_range(1, 20);
    end
    gen_left--;
    case (gen_mode)
      0: return 8'($urandom);
      1: return 8'(alpha_base + $urandom_range(0, alpha_span));
      default: begin
        seq_byte = (seq_byte + seq_step) % 256;
        return 8'(seq_byte);
      end
    endcase
  endfunction

  always @(posedge clk_i) begin : monitor
    marker_t got;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        got.position       = out_ch.position;
        got.short_distinct = out_ch.short_distinct;
        got.long_distinct  = out_ch.long_distinct;
        got.short_first    = out_ch.short_first;
        got.long_first     = out_ch.long_first;
        sb.check_result(got);
      end
      if (in_ch.valid && in_ch.ready) sb.note_request(in_ch.data_byte, in_ch.restart);
    end
  end

  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles != 0) begin
        stall_left  = hold_cycles;
        hold_cycles = 0;
      end
      if (stall_left != 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!rx_quiet && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  task automatic offer(input logic [7:0] b, input logic restart);
    int unsigned gap;
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.restart   <= restart;
    do @(posedge clk_i); while (!in_ch.ready);
    if (!tx_quiet && $urandom_range(0, 2) == 0) begin
      gap = pick_gap();
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (2) @(posedge clk_i);
  endtask

  // only called with the block idle
  task automatic set_lengths(input logic [LenW-1:0] s_len, input logic [LenW-1:0] l_len);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgShortLen;
    cfg_wdata_i <= s_len;
    @(posedge clk_i);
    cfg_idx_i   <= CfgLongLen;
    cfg_wdata_i <= l_len;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_len(CfgShortLen, s_len);
    sb.set_len(CfgLongLen, l_len);
  endtask

  task automatic run_random(input int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) offer(next_byte(), $urandom_range(0, 99) < 3);
  endtask

  initial begin : stimulus
    int unsigned     phase;
    int unsigned     i;
    logic [LenW-1:0] s_len;
    logic [LenW-1:0] l_len;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= CfgShortLen;
    cfg_wdata_i     <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= 8'h00;
    in_ch.restart   <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset lengths 4 and 14: repeats, a distance-four repeat, run capping, restart
    offer(8'h00, 1'b1);
    offer(8'h00, 1'b0);
    offer(8'hFF, 1'b0);
    offer(8'h01, 1'b0);
    offer(8'h80, 1'b0);
    offer(8'h7F, 1'b0);
    offer(8'hFF, 1'b0);
    offer(8'h55, 1'b0);
    offer(8'hAA, 1'b0);
    for (i = 0; i < 11; i++) offer(8'(8'h10 + i), 1'b0);
    offer(8'hAA, 1'b1);
    offer(8'h00, 1'b0);
    offer(8'hFF, 1'b0);
    offer(8'h00, 1'b0);

    for (phase = 0; phase < 10; phase++) begin
      wait_idle();
      // lengths below 2 and above the window clamp
      case (phase)
        0: begin s_len = 5'd0;  l_len = 5'd1;  end
        1: begin s_len = 5'd1;  l_len = 5'd31; end
        2: begin s_len = 5'd2;  l_len = 5'd16; end
        3: begin s_len = 5'd16; l_len = 5'd17; end
        4: begin s_len = 5'd31; l_len = 5'd0;  end
        5: begin s_len = 5'd17; l_len = 5'd2;  end
        default: begin
          s_len = LenW'($urandom_range(0, 31));
          l_len = LenW'($urandom_range(0, 31));
        end
      endcase
      set_lengths(s_len, l_len);
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      if (phase == 2) begin
        // long sink stall while requests keep coming, so the input backs up
        tx_quiet    = 1'b1;
        hold_cycles = 80;
        run_random(36);
        tx_quiet = 1'b0;
        run_random(36);
      end else if (phase == 5) begin
        run_random(36);
        wait_idle();
        run_random(36);
      end else begin
        run_random(72);
      end
    end

    wait_idle();
    repeat (4) @(posedge clk_i);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("PASS distinct_window_marker_detector_unit");
    end else begin
      $display("FAIL distinct_window_marker_detector_unit");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/dwm_pkg.sv
hw/rtl/dwm_ifs.sv
hw/rtl/dwm_cell.sv
hw/rtl/distinct_window_marker_detector_unit.sv
tb/distinct_window_marker_detector_unit_tb.sv
